>>> rtl/cmsk_pkg.sv
// ----------------------------------------------------------------------------
// cmsk_pkg: shared constants and types of the contact manifold slot keeper
//
// Slot count, register widths, action and kind codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package cmsk_pkg;

	localparam int SLOTS      = 4;
	localparam int SLOT_W     = 2;
	localparam int CNT_W      = 3;
	localparam int COORD_BITS = 20;
	localparam int THR_W      = 19;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(20);

	// item kinds
	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	// result actions
	localparam logic [1:0] ACT_NEAR    = 2'd0;
	localparam logic [1:0] ACT_APPEND  = 2'd1;
	localparam logic [1:0] ACT_EVICT   = 2'd2;
	localparam logic [1:0] ACT_REMOVED = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE,
		S_THR,
		S_THR2,
		S_NDIFF,
		S_NMUL,
		S_NACC,
		S_NCMP,
		S_DECIDE,
		S_DEEP,
		S_CAND,
		S_GATH,
		S_UV,
		S_T0,
		S_T1,
		S_T2,
		S_T3,
		S_T4,
		S_T5,
		S_T6,
		S_T7,
		S_PCMP,
		S_QCMP,
		S_WRITE,
		S_REM
	} state_t;

endpackage

`default_nettype wire

>>> rtl/contact_manifold_slot_keeper.sv
// ----------------------------------------------------------------------------
// contact_manifold_slot_keeper: four-point persistent contact manifold
//
// Matches, appends, evicts by quad area, and removes contact points by slot.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result word
// shows on slot/action/bad_slot/count_after for the one cycle that done is
// high and must be captured then, as the receiver cannot hold it off. All
// multiplication runs through one shared signed multiplier with a registered
// product, stepped by a sequencer. Busy stays high for 1 cycle on a remove,
// and done follows in the next cycle. An add keeps busy high through the
// threshold squaring (S_THR, S_THR2) and the nearest-point search, in which
// each stored point takes a difference, square and accumulate step per axis
// and then a compare, and after that through S_DECIDE and S_WRITE. When all
// four slots are full and no point is near, it adds the deepest-point search,
// a step to skip the deepest slot, and for each of the three area candidates
// the steps S_T0 to S_T7 per cross product component, nine components each.
// Configuration words are taken at any time with cfg_ready held high.
// ----------------------------------------------------------------------------
`default_nettype none

module contact_manifold_slot_keeper #(
	parameter int CB = cmsk_pkg::COORD_BITS
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire                          kind,
	input  wire  signed [CB-1:0]         local_x,
	input  wire  signed [CB-1:0]         local_y,
	input  wire  signed [CB-1:0]         local_z,
	input  wire  signed [CB-1:0]         penetration,
	input  wire  [cmsk_pkg::SLOT_W-1:0]  drop_slot,
	output logic                         done,
	output logic [cmsk_pkg::SLOT_W-1:0]  slot,
	output logic [1:0]                   action,
	output logic                         bad_slot,
	output logic [cmsk_pkg::CNT_W-1:0]   count_after,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [cmsk_pkg::THR_W-1:0]   cfg_data
);

	localparam int DW  = CB + 1;                 // coordinate difference
	localparam int TW  = 2 * DW + 1;             // cross component
	localparam int LW  = DW;                     // low split of magnitude
	localparam int MW  = (CB + 3 > cmsk_pkg::THR_W + 1) ? CB + 3 : cmsk_pkg::THR_W + 1;
	localparam int PRW = 2 * MW;
	localparam int AW  = 2 * TW;
	localparam int SW  = cmsk_pkg::SLOT_W;
	localparam int NW  = cmsk_pkg::CNT_W;

	cmsk_pkg::state_t state_q, state_d;

	logic [NW-1:0]                 cnt_q;
	logic [cmsk_pkg::THR_W-1:0]    thr_q;
	logic                          done_q;

	logic signed [CB-1:0]          st_q [cmsk_pkg::SLOTS][3];
	logic signed [CB-1:0]          sd_q [cmsk_pkg::SLOTS];
	logic signed [CB-1:0]          w_q  [4][3];
	logic signed [CB-1:0]          nd_q;
	logic signed [CB-1:0]          deepv_q;
	logic signed [DW-1:0]          dq_q;
	logic signed [DW-1:0]          u_q [3];
	logic signed [DW-1:0]          v_q [3];
	logic signed [PRW-1:0]         prod_q;
	logic signed [TW-1:0]          t_q;
	logic        [TW-2:0]          mag_q;
	logic        [AW-1:0]          acc_q, bval_q, qmax_q;
	logic        [SW-1:0]          i_q, k_q, p_q, cand_q, best_q, deep_q, slot_q;
	logic                          found_q, bad_q;
	logic        [1:0]             act_q;

	logic        [SW-1:0]          rd_idx;
	logic signed [CB-1:0]          rd_pt [3];
	logic signed [CB-1:0]          rd_dep;
	logic signed [MW-1:0]          mul_a, mul_b;
	logic signed [PRW-1:0]         mul_p;
	logic        [SW-1:0]          na, nb;
	logic        [AW-1:0]          prod_ext;
	logic                          rem_bad;
	logic        [SW-1:0]          gath_idx;

	// one read port into the slot store
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rd_pt[c] = st_q[rd_idx][c];
		end
		rd_dep = sd_q[rd_idx];
	end

	assign gath_idx = (i_q >= cand_q) ? i_q + SW'(1) : i_q;
	assign rem_bad  = ({1'b0, slot_q} >= cnt_q);
	assign prod_ext = AW'($unsigned(prod_q));
	assign mul_p    = mul_a * mul_b;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cmsk_pkg::S_IDLE: begin
				if (start) begin
					state_d = (kind == cmsk_pkg::KIND_REMOVE) ? cmsk_pkg::S_REM
					                                          : cmsk_pkg::S_THR;
				end
			end
			cmsk_pkg::S_THR:  state_d = cmsk_pkg::S_THR2;
			cmsk_pkg::S_THR2: begin
				state_d = (cnt_q == '0) ? cmsk_pkg::S_DECIDE : cmsk_pkg::S_NDIFF;
			end
			cmsk_pkg::S_NDIFF: state_d = cmsk_pkg::S_NMUL;
			cmsk_pkg::S_NMUL:  state_d = cmsk_pkg::S_NACC;
			cmsk_pkg::S_NACC: begin
				state_d = (k_q == SW'(2)) ? cmsk_pkg::S_NCMP : cmsk_pkg::S_NDIFF;
			end
			cmsk_pkg::S_NCMP: begin
				state_d = ({1'b0, i_q} + NW'(1) == cnt_q) ? cmsk_pkg::S_DECIDE
				                                         : cmsk_pkg::S_NDIFF;
			end
			cmsk_pkg::S_DECIDE: begin
				state_d = (found_q || cnt_q < NW'(cmsk_pkg::SLOTS)) ? cmsk_pkg::S_WRITE
				                                                    : cmsk_pkg::S_DEEP;
			end
			cmsk_pkg::S_DEEP: begin
				state_d = (i_q == SW'(3)) ? cmsk_pkg::S_CAND : cmsk_pkg::S_DEEP;
			end
			cmsk_pkg::S_CAND: begin
				if (cand_q == deep_q) begin
					state_d = (cand_q == SW'(3)) ? cmsk_pkg::S_WRITE : cmsk_pkg::S_CAND;
				end else begin
					state_d = cmsk_pkg::S_GATH;
				end
			end
			cmsk_pkg::S_GATH: begin
				state_d = (i_q == SW'(2)) ? cmsk_pkg::S_UV : cmsk_pkg::S_GATH;
			end
			cmsk_pkg::S_UV: state_d = cmsk_pkg::S_T0;
			cmsk_pkg::S_T0: state_d = cmsk_pkg::S_T1;
			cmsk_pkg::S_T1: state_d = cmsk_pkg::S_T2;
			cmsk_pkg::S_T2: state_d = cmsk_pkg::S_T3;
			cmsk_pkg::S_T3: state_d = cmsk_pkg::S_T4;
			cmsk_pkg::S_T4: state_d = cmsk_pkg::S_T5;
			cmsk_pkg::S_T5: state_d = cmsk_pkg::S_T6;
			cmsk_pkg::S_T6: state_d = cmsk_pkg::S_T7;
			cmsk_pkg::S_T7: begin
				state_d = (k_q == SW'(2)) ? cmsk_pkg::S_PCMP : cmsk_pkg::S_T0;
			end
			cmsk_pkg::S_PCMP: begin
				state_d = (p_q == SW'(2)) ? cmsk_pkg::S_QCMP : cmsk_pkg::S_UV;
			end
			cmsk_pkg::S_QCMP: begin
				state_d = (cand_q == SW'(3)) ? cmsk_pkg::S_WRITE : cmsk_pkg::S_CAND;
			end
			cmsk_pkg::S_WRITE: state_d = cmsk_pkg::S_IDLE;
			cmsk_pkg::S_REM:   state_d = cmsk_pkg::S_IDLE;
			default:           state_d = cmsk_pkg::S_IDLE;
		endcase
	end

	// outputs: handshake, read address and multiplier operands
	always_comb begin
		busy      = (state_q != cmsk_pkg::S_IDLE);
		cfg_ready = 1'b1;
		rd_idx    = i_q;
		mul_a     = '0;
		mul_b     = '0;
		na        = '0;
		nb        = '0;
		case (k_q)
			2'd0:    begin na = 2'd1; nb = 2'd2; end
			2'd1:    begin na = 2'd2; nb = 2'd0; end
			default: begin na = 2'd0; nb = 2'd1; end
		endcase
		case (state_q)
			cmsk_pkg::S_THR: begin
				mul_a = $signed(MW'(thr_q));
				mul_b = $signed(MW'(thr_q));
			end
			cmsk_pkg::S_NMUL: begin
				mul_a = MW'(dq_q);
				mul_b = MW'(dq_q);
			end
			cmsk_pkg::S_GATH: rd_idx = gath_idx;
			cmsk_pkg::S_REM:  rd_idx = SW'(cnt_q - NW'(1));
			cmsk_pkg::S_T0: begin
				mul_a = MW'(u_q[na]);
				mul_b = MW'(v_q[nb]);
			end
			cmsk_pkg::S_T1: begin
				mul_a = MW'(u_q[nb]);
				mul_b = MW'(v_q[na]);
			end
			cmsk_pkg::S_T4: begin
				mul_a = $signed(MW'(mag_q[LW-1:0]));
				mul_b = $signed(MW'(mag_q[LW-1:0]));
			end
			cmsk_pkg::S_T5: begin
				mul_a = $signed(MW'(mag_q[LW-1:0]));
				mul_b = $signed(MW'(mag_q[TW-2:LW]));
			end
			cmsk_pkg::S_T6: begin
				mul_a = $signed(MW'(mag_q[TW-2:LW]));
				mul_b = $signed(MW'(mag_q[TW-2:LW]));
			end
			default: ;
		endcase
	end

	assign done        = done_q;
	assign slot        = slot_q;
	assign action      = act_q;
	assign bad_slot    = bad_q;
	assign count_after = cnt_q;

	// control state: sequencer, count, threshold register, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmsk_pkg::S_IDLE;
			cnt_q   <= '0;
			thr_q   <= cmsk_pkg::THR_RESET;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == cmsk_pkg::S_WRITE) || (state_q == cmsk_pkg::S_REM);
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (state_q == cmsk_pkg::S_WRITE && act_q == cmsk_pkg::ACT_APPEND) begin
				cnt_q <= cnt_q + NW'(1);
			end
			if (state_q == cmsk_pkg::S_REM && !rem_bad) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	// datapath: one step of the shared multiplier and accumulator a cycle
	always_ff @(posedge clk) begin
		case (state_q)
			cmsk_pkg::S_IDLE: begin
				if (start) begin
					w_q[0][0] <= local_x;
					w_q[0][1] <= local_y;
					w_q[0][2] <= local_z;
					nd_q      <= penetration;
					slot_q    <= drop_slot;
					i_q       <= '0;
					k_q       <= '0;
					found_q   <= 1'b0;
					acc_q     <= '0;
				end
			end
			cmsk_pkg::S_THR:  prod_q <= mul_p;
			cmsk_pkg::S_THR2: bval_q <= prod_ext;
			// nearest-point search
			cmsk_pkg::S_NDIFF: dq_q <= DW'(w_q[0][k_q]) - DW'(rd_pt[k_q]);
			cmsk_pkg::S_NMUL:  prod_q <= mul_p;
			cmsk_pkg::S_NACC: begin
				acc_q <= acc_q + prod_ext;
				k_q   <= (k_q == SW'(2)) ? '0 : k_q + SW'(1);
			end
			cmsk_pkg::S_NCMP: begin
				if (acc_q < bval_q) begin
					bval_q  <= acc_q;
					slot_q  <= i_q;
					found_q <= 1'b1;
				end
				acc_q <= '0;
				i_q   <= i_q + SW'(1);
			end
			cmsk_pkg::S_DECIDE: begin
				bad_q <= 1'b0;
				i_q   <= '0;
				if (found_q) begin
					act_q <= cmsk_pkg::ACT_NEAR;
				end else if (cnt_q < NW'(cmsk_pkg::SLOTS)) begin
					act_q  <= cmsk_pkg::ACT_APPEND;
					slot_q <= SW'(cnt_q);
				end else begin
					act_q <= cmsk_pkg::ACT_EVICT;
				end
			end
			// protect the deepest point
			cmsk_pkg::S_DEEP: begin
				if (i_q == '0 || rd_dep < deepv_q) begin
					deepv_q <= rd_dep;
					deep_q  <= i_q;
				end
				i_q    <= i_q + SW'(1);
				cand_q <= '0;
				bval_q <= '0;
				best_q <= '0;
			end
			cmsk_pkg::S_CAND: begin
				i_q <= '0;
				if (cand_q == deep_q) begin
					cand_q <= cand_q + SW'(1);
					slot_q <= best_q;
				end
			end
			cmsk_pkg::S_GATH: begin
				for (int c = 0; c < 3; c++) begin
					w_q[i_q + SW'(1)][c] <= rd_pt[c];
				end
				i_q    <= i_q + SW'(1);
				p_q    <= '0;
				qmax_q <= '0;
			end
			// edge vectors of one opposite-edge pair
			cmsk_pkg::S_UV: begin
				for (int c = 0; c < 3; c++) begin
					case (p_q)
						2'd0: begin
							u_q[c] <= DW'(w_q[0][c]) - DW'(w_q[1][c]);
							v_q[c] <= DW'(w_q[2][c]) - DW'(w_q[3][c]);
						end
						2'd1: begin
							u_q[c] <= DW'(w_q[0][c]) - DW'(w_q[2][c]);
							v_q[c] <= DW'(w_q[1][c]) - DW'(w_q[3][c]);
						end
						default: begin
							u_q[c] <= DW'(w_q[0][c]) - DW'(w_q[3][c]);
							v_q[c] <= DW'(w_q[1][c]) - DW'(w_q[2][c]);
						end
					endcase
				end
				acc_q <= '0;
				k_q   <= '0;
			end
			// one cross component, squared in split halves
			cmsk_pkg::S_T0: prod_q <= mul_p;
			cmsk_pkg::S_T1: begin
				prod_q <= mul_p;
				t_q    <= TW'(prod_q);
			end
			cmsk_pkg::S_T2: t_q <= t_q - TW'(prod_q);
			cmsk_pkg::S_T3: mag_q <= t_q[TW-1] ? (TW-1)'(-t_q) : t_q[TW-2:0];
			cmsk_pkg::S_T4: prod_q <= mul_p;
			cmsk_pkg::S_T5: begin
				prod_q <= mul_p;
				acc_q  <= acc_q + prod_ext;
			end
			cmsk_pkg::S_T6: begin
				prod_q <= mul_p;
				acc_q  <= acc_q + (prod_ext << (LW + 1));
			end
			cmsk_pkg::S_T7: begin
				acc_q <= acc_q + (prod_ext << (2 * LW));
				k_q   <= (k_q == SW'(2)) ? '0 : k_q + SW'(1);
			end
			cmsk_pkg::S_PCMP: begin
				if (acc_q > qmax_q) begin
					qmax_q <= acc_q;
				end
				p_q <= p_q + SW'(1);
			end
			// keep the first candidate of largest area
			cmsk_pkg::S_QCMP: begin
				if (qmax_q > bval_q) begin
					bval_q <= qmax_q;
					best_q <= cand_q;
				end
				slot_q <= (qmax_q > bval_q) ? cand_q : best_q;
				cand_q <= cand_q + SW'(1);
			end
			cmsk_pkg::S_WRITE: begin
				for (int c = 0; c < 3; c++) begin
					st_q[slot_q][c] <= w_q[0][c];
				end
				sd_q[slot_q] <= nd_q;
			end
			// move the last point into the freed slot
			cmsk_pkg::S_REM: begin
				act_q <= cmsk_pkg::ACT_REMOVED;
				bad_q <= rem_bad;
				if (!rem_bad) begin
					for (int c = 0; c < 3; c++) begin
						st_q[slot_q][c] <= rd_pt[c];
					end
					sd_q[slot_q] <= rd_dep;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire
